>>> rtl/ipv4v_pkg.sv
// ----------------------------------------------------------------------------
// ipv4v_pkg
// Shared constants, codes and types for the IPv4 prefix text validator.
// ----------------------------------------------------------------------------
package ipv4v_pkg;

  // default bounds
  localparam int DEF_MIN_ADDR_CHARS    = 7;
  localparam int DEF_MAX_ADDR_CHARS    = 15;
  localparam int DEF_MAX_DOTS          = 3;
  localparam int DEF_MIN_PREFIX_DIGITS = 1;
  localparam int DEF_MAX_PREFIX_DIGITS = 2;
  localparam int DEF_MAX_PREFIX_VALUE  = 32;

  // characters and limits
  localparam logic [7:0] ZERO_CODE = 8'd48;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [8:0] OCTET_MAX = 9'd255;

  // character classes
  localparam logic [1:0] CLS_DIGIT = 2'd0;
  localparam logic [1:0] CLS_DOT   = 2'd1;
  localparam logic [1:0] CLS_SLASH = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  // fail codes
  localparam logic [3:0] FAIL_NONE        = 4'd0;
  localparam logic [3:0] FAIL_ADDR_LEN    = 4'd1;
  localparam logic [3:0] FAIL_OCTET       = 4'd2;
  localparam logic [3:0] FAIL_DOTS        = 4'd3;
  localparam logic [3:0] FAIL_BAD_CHAR    = 4'd4;
  localparam logic [3:0] FAIL_NO_SLASH    = 4'd5;
  localparam logic [3:0] FAIL_PREFIX_LEN  = 4'd6;
  localparam logic [3:0] FAIL_PREFIX_CHAR = 4'd7;
  localparam logic [3:0] FAIL_PREFIX_VAL  = 4'd8;

  // classified character queue
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic       mode;
    logic       last;
    logic [1:0] cls;
    logic [3:0] digit;
  } entry_t;

endpackage

>>> rtl/ipv4_prefix_text_validator_top.sv
// ----------------------------------------------------------------------------
// ipv4_prefix_text_validator_top
// IPv4 dotted address / address-with-prefix text validator.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: one ASCII character per transaction
//   on char_code, with last_char marking the final character of a string.
//   A transaction is taken when push is high and full is low.
//   Result side is a queue read port: while empty is low, is_valid and
//   fail_code hold the verdict of the oldest finished string; pop with
//   empty low takes it. One result per string, none for other characters.
//   The config channel (cfg_valid/cfg_ready/cfg_prefix_mode) sets prefix
//   mode; cfg_ready is always high. Change it only while the block is idle.
// Timing:
//   One character per cycle sustained while results are popped in time; the
//   per-character decimal accumulate sets the rate. A character sits in a
//   two-entry queue after classification; the checker consumes one entry
//   per cycle unless a final character waits for the result slot, into which
//   the verdict of its string is registered when the checker takes it.
// Reset and stall:
//   rst (synchronous) clears the per-string state, the queue and the result
//   slot, and sets prefix mode to plain. If the result slot is not popped,
//   the checker still drains non-final characters; it halts only on a final
//   character, the queue fills and full goes high.
// ----------------------------------------------------------------------------
module ipv4_prefix_text_validator_top #(
  parameter int MIN_ADDR_CHARS    = ipv4v_pkg::DEF_MIN_ADDR_CHARS,
  parameter int MAX_ADDR_CHARS    = ipv4v_pkg::DEF_MAX_ADDR_CHARS,
  parameter int MAX_DOTS          = ipv4v_pkg::DEF_MAX_DOTS,
  parameter int MIN_PREFIX_DIGITS = ipv4v_pkg::DEF_MIN_PREFIX_DIGITS,
  parameter int MAX_PREFIX_DIGITS = ipv4v_pkg::DEF_MAX_PREFIX_DIGITS,
  parameter int MAX_PREFIX_VALUE  = ipv4v_pkg::DEF_MAX_PREFIX_VALUE
) (
  input  logic       clk,
  input  logic       rst,
  // config channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_prefix_mode,
  // character input
  input  logic       push,
  output logic       full,
  input  logic [7:0] char_code,
  input  logic       last_char,
  // result output
  output logic       empty,
  input  logic       pop,
  output logic       is_valid,
  output logic [3:0] fail_code
);

  logic              prefix_mode;
  ipv4v_pkg::entry_t front_entry;
  ipv4v_pkg::entry_t q_entry;
  logic              q_valid;
  logic              q_take;

  assign cfg_ready = 1'b1;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      prefix_mode <= cfg_prefix_mode;
    end
  end

  // classify and tag each character with the mode in force at its transaction
  ipv4v_front u_front (
    .char_code (char_code),
    .last_char (last_char),
    .mode      (prefix_mode),
    .entry     (front_entry)
  );

  ipv4v_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push && !full),
    .wr_data  (front_entry),
    .full     (full),
    .rd_en    (q_take),
    .rd_data  (q_entry),
    .rd_valid (q_valid)
  );

  ipv4v_back #(
    .MIN_ADDR_CHARS    (MIN_ADDR_CHARS),
    .MAX_ADDR_CHARS    (MAX_ADDR_CHARS),
    .MAX_DOTS          (MAX_DOTS),
    .MIN_PREFIX_DIGITS (MIN_PREFIX_DIGITS),
    .MAX_PREFIX_DIGITS (MAX_PREFIX_DIGITS),
    .MAX_PREFIX_VALUE  (MAX_PREFIX_VALUE)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry       (q_entry),
    .entry_valid (q_valid),
    .entry_take  (q_take),
    .empty       (empty),
    .pop         (pop),
    .is_valid    (is_valid),
    .fail_code   (fail_code)
  );

endmodule

>>> rtl/ipv4v_front.sv
// ----------------------------------------------------------------------------
// ipv4v_front
// Classifies each incoming character and tags it with the current mode.
// ----------------------------------------------------------------------------
module ipv4v_front (
  input  logic                [7:0] char_code,
  input  logic                      last_char,
  input  logic                      mode,
  output ipv4v_pkg::entry_t         entry
);

  logic [7:0] offset;

  assign offset = char_code - ipv4v_pkg::ZERO_CODE;

  always_comb begin
    entry.mode  = mode;
    entry.last  = last_char;
    entry.digit = offset[3:0];
    if (char_code >= ipv4v_pkg::ZERO_CODE && offset <= 8'd9) begin
      entry.cls = ipv4v_pkg::CLS_DIGIT;
    end else if (char_code == ipv4v_pkg::CH_DOT) begin
      entry.cls = ipv4v_pkg::CLS_DOT;
    end else if (char_code == ipv4v_pkg::CH_SLASH) begin
      entry.cls = ipv4v_pkg::CLS_SLASH;
    end else begin
      entry.cls = ipv4v_pkg::CLS_OTHER;
    end
  end

endmodule

>>> rtl/ipv4v_queue.sv
// ----------------------------------------------------------------------------
// ipv4v_queue
// Short register queue between the classifier and the checker.
// ----------------------------------------------------------------------------
module ipv4v_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  ipv4v_pkg::entry_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output ipv4v_pkg::entry_t rd_data,
  output logic              rd_valid
);

  localparam int PW = (ipv4v_pkg::QUEUE_DEPTH > 1) ? $clog2(ipv4v_pkg::QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(ipv4v_pkg::QUEUE_DEPTH + 1);

  ipv4v_pkg::entry_t slots [ipv4v_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(ipv4v_pkg::QUEUE_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PW'(ipv4v_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PW'(ipv4v_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> rtl/ipv4v_back.sv
// ----------------------------------------------------------------------------
// ipv4v_back
// Per-string checker state, final verdict and the result register.
// ----------------------------------------------------------------------------
module ipv4v_back #(
  parameter int MIN_ADDR_CHARS    = ipv4v_pkg::DEF_MIN_ADDR_CHARS,
  parameter int MAX_ADDR_CHARS    = ipv4v_pkg::DEF_MAX_ADDR_CHARS,
  parameter int MAX_DOTS          = ipv4v_pkg::DEF_MAX_DOTS,
  parameter int MIN_PREFIX_DIGITS = ipv4v_pkg::DEF_MIN_PREFIX_DIGITS,
  parameter int MAX_PREFIX_DIGITS = ipv4v_pkg::DEF_MAX_PREFIX_DIGITS,
  parameter int MAX_PREFIX_VALUE  = ipv4v_pkg::DEF_MAX_PREFIX_VALUE
) (
  input  logic              clk,
  input  logic              rst,
  input  ipv4v_pkg::entry_t entry,
  input  logic              entry_valid,
  output logic              entry_take,
  output logic              empty,
  input  logic              pop,
  output logic              is_valid,
  output logic        [3:0] fail_code
);

  logic [4:0] address_length, address_length_next;
  logic [8:0] octet_value, octet_value_next;
  logic [2:0] dot_total, dot_total_next;
  logic [2:0] first_address_error, first_address_error_next;
  logic       after_slash, after_slash_next;
  logic [1:0] prefix_digit_total, prefix_digit_total_next;
  logic [6:0] prefix_value, prefix_value_next;
  logic       prefix_nondigit_seen, prefix_nondigit_seen_next;
  logic       out_valid;

  logic [12:0] octet_acc;
  logic [10:0] prefix_acc;
  logic [3:0]  dot_inc;
  logic [3:0]  verdict;

  // a last character needs the result slot; others always drain
  assign entry_take = entry_valid && (!entry.last || !out_valid || pop);
  assign empty      = !out_valid;

  assign octet_acc  = 13'(octet_value) * 13'd10 + 13'(entry.digit);
  assign prefix_acc = 11'(prefix_value) * 11'd10 + 11'(entry.digit);
  assign dot_inc    = {1'b0, dot_total} + 4'd1;

  always_comb begin
    address_length_next       = address_length;
    octet_value_next          = octet_value;
    dot_total_next            = dot_total;
    first_address_error_next  = first_address_error;
    after_slash_next          = after_slash;
    prefix_digit_total_next   = prefix_digit_total;
    prefix_value_next         = prefix_value;
    prefix_nondigit_seen_next = prefix_nondigit_seen;

    if (entry.mode && after_slash) begin
      if (prefix_digit_total != 2'd3) begin
        prefix_digit_total_next = prefix_digit_total + 2'd1;
      end
      if (entry.cls == ipv4v_pkg::CLS_DIGIT) begin
        if (!prefix_nondigit_seen) begin
          prefix_value_next = (prefix_acc > 11'd127) ? 7'd127 : prefix_acc[6:0];
        end
      end else begin
        prefix_nondigit_seen_next = 1'b1;
      end
    end else if (entry.mode && entry.cls == ipv4v_pkg::CLS_SLASH) begin
      after_slash_next = 1'b1;
    end else begin
      if (address_length != 5'd31) begin
        address_length_next = address_length + 5'd1;
      end
      if (first_address_error == ipv4v_pkg::FAIL_NONE[2:0]) begin
        case (entry.cls)
          ipv4v_pkg::CLS_DIGIT: begin
            octet_value_next = (octet_acc > 13'd511) ? 9'd511 : octet_acc[8:0];
          end
          ipv4v_pkg::CLS_DOT: begin
            if (octet_value > ipv4v_pkg::OCTET_MAX) begin
              first_address_error_next = ipv4v_pkg::FAIL_OCTET[2:0];
            end else begin
              octet_value_next = '0;
              dot_total_next   = dot_inc[3] ? 3'd7 : dot_inc[2:0];
              if (dot_inc > 4'(MAX_DOTS)) begin
                first_address_error_next = ipv4v_pkg::FAIL_DOTS[2:0];
              end
            end
          end
          default: begin
            first_address_error_next = ipv4v_pkg::FAIL_BAD_CHAR[2:0];
          end
        endcase
      end
    end
  end

  // verdict on the state as it stands after this character
  always_comb begin
    if (entry.mode && !after_slash_next) begin
      verdict = ipv4v_pkg::FAIL_NO_SLASH;
    end else if (entry.mode && (prefix_digit_total_next < 2'(MIN_PREFIX_DIGITS) ||
                                prefix_digit_total_next > 2'(MAX_PREFIX_DIGITS))) begin
      verdict = ipv4v_pkg::FAIL_PREFIX_LEN;
    end else if (entry.mode && prefix_nondigit_seen_next) begin
      verdict = ipv4v_pkg::FAIL_PREFIX_CHAR;
    end else if (entry.mode && prefix_value_next > 7'(MAX_PREFIX_VALUE)) begin
      verdict = ipv4v_pkg::FAIL_PREFIX_VAL;
    end else if (address_length_next < 5'(MIN_ADDR_CHARS) ||
                 address_length_next > 5'(MAX_ADDR_CHARS)) begin
      verdict = ipv4v_pkg::FAIL_ADDR_LEN;
    end else if (first_address_error_next != ipv4v_pkg::FAIL_NONE[2:0]) begin
      verdict = {1'b0, first_address_error_next};
    end else if (octet_value_next > ipv4v_pkg::OCTET_MAX) begin
      verdict = ipv4v_pkg::FAIL_OCTET;
    end else begin
      verdict = ipv4v_pkg::FAIL_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      address_length       <= '0;
      octet_value          <= '0;
      dot_total            <= '0;
      first_address_error  <= '0;
      after_slash          <= 1'b0;
      prefix_digit_total   <= '0;
      prefix_value         <= '0;
      prefix_nondigit_seen <= 1'b0;
      out_valid            <= 1'b0;
    end else begin
      if (entry_take && entry.last) begin
        address_length       <= '0;
        octet_value          <= '0;
        dot_total            <= '0;
        first_address_error  <= '0;
        after_slash          <= 1'b0;
        prefix_digit_total   <= '0;
        prefix_value         <= '0;
        prefix_nondigit_seen <= 1'b0;
        out_valid            <= 1'b1;
      end else begin
        if (entry_take) begin
          address_length       <= address_length_next;
          octet_value          <= octet_value_next;
          dot_total            <= dot_total_next;
          first_address_error  <= first_address_error_next;
          after_slash          <= after_slash_next;
          prefix_digit_total   <= prefix_digit_total_next;
          prefix_value         <= prefix_value_next;
          prefix_nondigit_seen <= prefix_nondigit_seen_next;
        end
        if (pop) begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (entry_take && entry.last) begin
      fail_code <= verdict;
      is_valid  <= (verdict == ipv4v_pkg::FAIL_NONE);
    end
  end

endmodule

>>> rtl/ipv4v_checker.sv
// ----------------------------------------------------------------------------
// ipv4v_checker
// Port-level checks for the IPv4 prefix text validator.
// ----------------------------------------------------------------------------
module ipv4v_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_ready,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic       is_valid,
  input logic [3:0] fail_code
);

  // reset leaves no stale result and an open input
  a_reset_clears: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("result or full flag survived reset");

  // a held result keeps its verdict until taken
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
      (!empty && !pop) |=> (!empty && $stable(fail_code) && $stable(is_valid)))
    else $error("waiting result changed before pop");

  // valid flag and fail code agree
  a_valid_code: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (is_valid == (fail_code == ipv4v_pkg::FAIL_NONE)))
    else $error("is_valid disagrees with fail_code");

  // fail code stays within the defined range and the config port stays ready
  a_code_range: assert property (@(posedge clk) disable iff (rst)
      !empty |-> (fail_code <= ipv4v_pkg::FAIL_PREFIX_VAL && cfg_ready))
    else $error("fail code out of range or config port blocked");

endmodule

bind ipv4_prefix_text_validator_top ipv4v_checker u_checker (.*);

>>> test/ipv4_prefix_text_validator_top_tb.sv
// ----------------------------------------------------------------------------
// ipv4_prefix_text_validator_top_tb
// Self-checking bench for the IPv4 dotted / address-with-prefix text checker:
// strings go in one character per transaction, and a model in the bench
// predicts each verdict. Directed strings cover every fail code. Random
// strings, mostly well formed, follow in phases that alternate plain and
// prefix mode, with random gaps on both sides and long output holds.
// ----------------------------------------------------------------------------
module ipv4_prefix_text_validator_top_tb;

  // run control
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 6;    // result is registered once the checker takes the last char
  localparam int HOLD_CYCLES  = 300;  // long output stall, fills the input queue
  localparam int PHASE_CHARS  = 205;
  localparam int PHASES       = 6;

  typedef struct packed {
    logic       valid;
    logic [3:0] code;
  } verdict_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the per-string checker state and holds the verdicts
  // still owed by the block, oldest first.
  // --------------------------------------------------------------------------
  class validator_scoreboard;
    bit         prefix_mode;
    logic [4:0] addr_len;     // saturates at 31
    logic [8:0] octet_val;    // saturates at 511
    logic [2:0] dot_cnt;      // saturates at 7
    logic [2:0] scan_err;     // first address error, 0 = none
    bit         slash_seen;
    logic [1:0] pfx_chars;    // saturates at 3
    logic [6:0] pfx_val;      // saturates at 127
    bit         pfx_bad;
    verdict_t   owed[$];
    int unsigned errors;

    function new();
      prefix_mode = 1'b0;
      errors = 0;
      clear();
    endfunction

    function void clear();
      addr_len   = '0;
      octet_val  = '0;
      dot_cnt    = '0;
      scan_err   = '0;
      slash_seen = 1'b0;
      pfx_chars  = '0;
      pfx_val    = '0;
      pfx_bad    = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= ipv4v_pkg::ZERO_CODE && c <= ipv4v_pkg::ZERO_CODE + 8'd9;
    endfunction

    function void scan_address(logic [7:0] c);
      int v;
      if (addr_len < 5'd31) addr_len++;
      if (scan_err != ipv4v_pkg::FAIL_NONE[2:0]) return;
      if (is_digit(c)) begin
        v = int'(octet_val) * 10 + int'(c - ipv4v_pkg::ZERO_CODE);
        octet_val = (v > 511) ? 9'd511 : 9'(v);
      end else if (c == ipv4v_pkg::CH_DOT) begin
        v = int'(dot_cnt) + 1;
        if (octet_val > ipv4v_pkg::OCTET_MAX) begin
          scan_err = ipv4v_pkg::FAIL_OCTET[2:0];
          return;
        end
        octet_val = '0;
        dot_cnt = (v > 7) ? 3'd7 : 3'(v);
        if (v > ipv4v_pkg::DEF_MAX_DOTS) scan_err = ipv4v_pkg::FAIL_DOTS[2:0];
      end else begin
        scan_err = ipv4v_pkg::FAIL_BAD_CHAR[2:0];
      end
    endfunction

    function void scan_prefix(logic [7:0] c);
      int v;
      if (pfx_chars < 2'd3) pfx_chars++;
      if (is_digit(c)) begin
        if (!pfx_bad) begin
          v = int'(pfx_val) * 10 + int'(c - ipv4v_pkg::ZERO_CODE);
          pfx_val = (v > 127) ? 7'd127 : 7'(v);
        end
      end else begin
        pfx_bad = 1'b1;
      end
    endfunction

    function logic [3:0] fail_of_string();
      if (prefix_mode) begin
        if (!slash_seen) return ipv4v_pkg::FAIL_NO_SLASH;
        if (pfx_chars < ipv4v_pkg::DEF_MIN_PREFIX_DIGITS ||
            pfx_chars > ipv4v_pkg::DEF_MAX_PREFIX_DIGITS)
          return ipv4v_pkg::FAIL_PREFIX_LEN;
        if (pfx_bad) return ipv4v_pkg::FAIL_PREFIX_CHAR;
        if (pfx_val > ipv4v_pkg::DEF_MAX_PREFIX_VALUE) return ipv4v_pkg::FAIL_PREFIX_VAL;
      end
      if (addr_len < ipv4v_pkg::DEF_MIN_ADDR_CHARS || addr_len > ipv4v_pkg::DEF_MAX_ADDR_CHARS)
        return ipv4v_pkg::FAIL_ADDR_LEN;
      if (scan_err != ipv4v_pkg::FAIL_NONE[2:0]) return {1'b0, scan_err};
      if (octet_val > ipv4v_pkg::OCTET_MAX) return ipv4v_pkg::FAIL_OCTET;
      return ipv4v_pkg::FAIL_NONE;
    endfunction

    // one accepted input transaction
    function void note_char(logic [7:0] c, logic last);
      verdict_t v;
      if (prefix_mode && slash_seen) scan_prefix(c);
      else if (prefix_mode && c == ipv4v_pkg::CH_SLASH) slash_seen = 1'b1;
      else scan_address(c);
      if (last) begin
        v.code  = fail_of_string();
        v.valid = (v.code == ipv4v_pkg::FAIL_NONE);
        owed.push_back(v);
        clear();
      end
    endfunction

    // one accepted output transaction
    function void check_result(logic valid, logic [3:0] code);
      verdict_t v;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result is_valid=%0b fail_code=%0d", $time, valid, code);
        errors++;
        return;
      end
      v = owed.pop_front();
      if (valid !== v.valid) begin
        $display("%0t: is_valid mismatch expected %0b actual %0b", $time, v.valid, valid);
        errors++;
      end
      if (code !== v.code) begin
        $display("%0t: fail_code mismatch expected %0d actual %0d", $time, v.code, code);
        errors++;
      end
    endfunction

    function int outstanding();
      return owed.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT signals, inputs all driven to known values from time zero
  // --------------------------------------------------------------------------
  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_prefix_mode = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] char_code = '0;
  logic       last_char = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       is_valid;
  logic [3:0] fail_code;

  ipv4_prefix_text_validator_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_prefix_mode (cfg_prefix_mode),
    .push            (push),
    .full            (full),
    .char_code       (char_code),
    .last_char       (last_char),
    .empty           (empty),
    .pop             (pop),
    .is_valid        (is_valid),
    .fail_code       (fail_code)
  );

  always #5 clk = ~clk;

  validator_scoreboard sb = new();

  logic [7:0] text_buf[$];   // string being sent, one byte per transaction
  int         chars_sent = 0;
  bit         idle_on    = 1'b1;  // random gaps on both sides
  bit         hold_req   = 1'b0;  // asks the output side for a long stall
  int         cycle_count = 0;

  // --------------------------------------------------------------------------
  // Watchdog: a hung handshake ends the run here.
  // --------------------------------------------------------------------------
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side. pop changes only right after an edge, and is_valid and
  // fail_code are read right after the edge that took the transaction, so
  // they still hold the values the block saw at that edge.
  // --------------------------------------------------------------------------
  initial begin
    int hold_left;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        // long stall: input keeps pushing until full rises
        hold_req = 1'b0;
        pop <= 1'b0;
        hold_left = HOLD_CYCLES;
        while (hold_left > 0) begin
          @(posedge clk);
          hold_left--;
        end
      end else if (idle_on && $urandom_range(0, 99) < 20) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        pop <= 1'b1;
        @(posedge clk);
        if (!empty) sb.check_result(is_valid, fail_code);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side: sends text_buf, last_char on its final byte. push stays high
  // from one character to the next unless a random gap comes in between.
  // --------------------------------------------------------------------------
  task automatic send_buffer();
    int i;
    bit fin;
    for (i = 0; i < text_buf.size(); i++) begin
      fin = (i == text_buf.size() - 1);
      if (idle_on && $urandom_range(0, 99) < 12) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      push      <= 1'b1;
      char_code <= text_buf[i];
      last_char <= fin;
      do @(posedge clk); while (full);
      sb.note_char(text_buf[i], fin);
      chars_sent++;
    end
  endtask

  task automatic append_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  // Config writes only when the block is idle: all verdicts back, and a
  // DRAIN_CYCLES wait for a trailing non-final char still in the checker.
  task automatic set_mode(bit m);
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_prefix_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.prefix_mode = m;
  endtask

  task automatic send_text(string s);
    text_buf.delete();
    append_text(s);
    send_buffer();
  endtask

  // one octet, mostly legal, sometimes empty, oversized or saturating
  task automatic append_octet();
    int r;
    r = $urandom_range(0, 99);
    if (r < 6) return;
    else if (r < 14) append_text($sformatf("%0d", $urandom_range(256, 999)));
    else if (r < 20) append_text($sformatf("0%0d", $urandom_range(0, 99)));
    else if (r < 24) append_text("9999");
    else append_text($sformatf("%0d", $urandom_range(0, 255)));
  endtask

  // the part after the slash: legal values, then each way it can break
  task automatic append_prefix();
    int r;
    text_buf.push_back(ipv4v_pkg::CH_SLASH);
    r = $urandom_range(0, 99);
    if (r < 55) append_text($sformatf("%0d", $urandom_range(0, 32)));
    else if (r < 65) append_text($sformatf("%0d", $urandom_range(33, 99)));
    else if (r < 70) append_text($sformatf("%0d", $urandom_range(100, 999)));
    else if (r < 76) return;
    else if (r < 84) begin
      append_text($sformatf("%0d", $urandom_range(0, 9)));
      text_buf.push_back(8'($urandom_range(0, 255)));
    end else if (r < 88) begin
      append_text($sformatf("%0d", $urandom_range(0, 9)));
      text_buf.push_back(ipv4v_pkg::CH_SLASH);   // second slash
    end else if (r < 92) append_text("9999");
    else append_text($sformatf("0%0d", $urandom_range(0, 9)));
  endtask

  task automatic build_random_string();
    int kind, n, i, r;
    text_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind < 72) begin
      // well-formed shape with random content
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 4;
      for (i = 0; i < n; i++) begin
        if (i > 0) text_buf.push_back(ipv4v_pkg::CH_DOT);
        append_octet();
      end
      if (sb.prefix_mode ? ($urandom_range(0, 99) < 90) : ($urandom_range(0, 99) < 8))
        append_prefix();
      if (text_buf.size() > 0 && $urandom_range(0, 99) < 12)
        text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    end else if (kind < 88) begin
      // noise, biased toward the characters that matter
      n = $urandom_range(1, 35);
      for (i = 0; i < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 35) text_buf.push_back(8'(ipv4v_pkg::ZERO_CODE + $urandom_range(0, 9)));
        else if (r < 55) text_buf.push_back(ipv4v_pkg::CH_DOT);
        else if (r < 62) text_buf.push_back(ipv4v_pkg::CH_SLASH);
        else text_buf.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      // long digit/dot runs, can push the length counter to saturation
      n = $urandom_range(14, 40);
      for (i = 0; i < n; i++)
        text_buf.push_back(($urandom_range(0, 3) == 0) ? ipv4v_pkg::CH_DOT :
                           8'(ipv4v_pkg::ZERO_CODE + $urandom_range(0, 9)));
    end
    if (text_buf.size() == 0)
      text_buf.push_back(8'(ipv4v_pkg::ZERO_CODE + $urandom_range(0, 9)));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int phase, goal;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain mode: ok, max length, octet over 255 (first and final), too
    // many dots, bad char, slash in plain mode, short, empty octets, high byte
    set_mode(1'b0);
    send_text("1.2.3.4");
    send_text("255.255.255.255");
    send_text("256.1.2.3");
    send_text("1.2.3.256");
    send_text("1.2.3.4.5");
    send_text("1.2.a.4");
    send_text("1/2.3.4");
    send_text("1.2");
    send_text("..1.234");
    text_buf.delete();
    append_text("1.2.3.");
    text_buf.push_back(8'hFF);
    send_buffer();

    // prefix mode: ok at both value ends, no slash, empty and too long
    // prefix, non-digit, second slash, value over max, short address part
    set_mode(1'b1);
    send_text("1.2.3.4/32");
    send_text("1.2.3.4/0");
    send_text("1.2.3.4");
    send_text("1.2.3.4/");
    send_text("1.2.3.4/123");
    send_text("1.2.3.4/3a");
    send_text("1.2.3.4/1/");
    send_text("1.2.3.4/33");
    send_text("1.2/3");

    // random phases alternate the mode; two of them open with a long hold
    // on the output, and the last runs with no gaps at all
    for (phase = 0; phase < PHASES; phase++) begin
      set_mode(phase % 2 == 0);
      if (phase == 1 || phase == 3) hold_req = 1'b1;
      if (phase == PHASES - 1) idle_on = 1'b0;
      goal = chars_sent + PHASE_CHARS;
      while (chars_sent < goal) begin
        build_random_string();
        send_buffer();
      end
    end

    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 2) @(posedge clk);
    if (sb.errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
